// File: rtl/core/lav_pkg.sv
// Shared types and constants for the look-at view matrix pipeline.
package lav_pkg;

    localparam int FRAC_BITS   = 30;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 31;
    localparam int NORM_LAT    = 6 + SQRT_STEPS + DIV_STEPS + 1;
    localparam int CROSS_LAT   = 2;
    localparam int SHIFT_LAT   = 3;

    // Scaled magnitudes, signs and zero flag carried through the normaliser
    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } norm_side_t;

endpackage

// File: rtl/core/lav_delay.sv
// Delay line with clock enable for data that runs beside the pipeline.
module lav_delay #(
    parameter int W     = 96,
    parameter int DEPTH = 70
) (
    input  logic         clk,
    input  logic         ce,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] dly_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dly_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule

// File: rtl/core/lav_norm.sv
// Pipelined vector normaliser: scale, square root by digits, division by bits.
module lav_norm #(
    parameter int W = 33
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [2:0][W-1:0]   v,
    output logic                out_valid,
    output logic [2:0][31:0]    u
);

    localparam int LAT = lav_pkg::NORM_LAT;
    localparam int PW  = $clog2(W);
    localparam int SN  = lav_pkg::SQRT_STEPS;
    localparam int DN  = lav_pkg::DIV_STEPS;
    localparam int FB  = lav_pkg::FRAC_BITS;

    logic [LAT-1:0] vld_reg;

    logic [2:0][W-1:0]  mag1_reg, mag2_reg, mag3_reg;
    logic [2:0]         neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [W-1:0]       max2_reg;
    logic [PW-1:0]      p3_reg;
    logic               zero3_reg, zero4_reg, zero5_reg;
    logic [2:0][30:0]   a4_reg, a5_reg;
    logic [2:0][61:0]   sq5_reg;
    logic [63:0]        sum6_reg;
    lav_pkg::norm_side_t side6_reg;

    logic [63:0]         n_reg [SN];
    logic [63:0]         r_reg [SN];
    lav_pkg::norm_side_t sside_reg [SN];

    logic [2:0][61:0]    rem_reg [DN];
    logic [2:0][30:0]    q_reg [DN];
    logic [31:0]         len_reg [DN];
    lav_pkg::norm_side_t dside_reg [DN];

    logic [2:0][31:0]    u_reg;

    logic [W-1:0]       max_c;
    logic [PW-1:0]      p_c;
    logic [2:0][30:0]   a_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_comb
    begin
        logic [W-1:0] m01;
        m01   = (mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1];
        max_c = (m01 > mag1_reg[2]) ? m01 : mag1_reg[2];
    end

    // Position of the leading one of the largest magnitude
    always_comb
    begin
        p_c = '0;
        for (int i = 0; i < W; i++)
        begin
            if (max2_reg[i])
            begin
                p_c = PW'(i);
            end
        end
    end

    // Bring the largest magnitude into [2^30, 2^31)
    always_comb
    begin
        logic [W+FB-1:0] ext;
        for (int i = 0; i < 3; i++)
        begin
            ext    = {mag3_reg[i], {FB{1'b0}}} >> p3_reg;
            a_c[i] = ext[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= v[i][W-1] ? (~v[i] + W'(1)) : v[i];
                neg1_reg[i] <= v[i][W-1];
                sq5_reg[i]  <= 62'(a4_reg[i]) * 62'(a4_reg[i]);
            end
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            max2_reg  <= max_c;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            p3_reg    <= p_c;
            zero3_reg <= (max2_reg == '0);
            a4_reg    <= a_c;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            a5_reg    <= a4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            sum6_reg  <= 64'(sq5_reg[0]) + 64'(sq5_reg[1]) + 64'(sq5_reg[2]);
            side6_reg.mag  <= a5_reg;
            side6_reg.neg  <= neg5_reg;
            side6_reg.zero <= zero5_reg;
        end
    end

    // Square root, one result bit per stage
    for (genvar k = 0; k < SN; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0]         n_in;
        logic [63:0]         r_in;
        logic [63:0]         trial;
        lav_pkg::norm_side_t s_in;

        if (k == 0)
        begin : g_first
            assign n_in = sum6_reg;
            assign r_in = '0;
            assign s_in = side6_reg;
        end
        else
        begin : g_next
            assign n_in = n_reg[k-1];
            assign r_in = r_reg[k-1];
            assign s_in = sside_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (n_in >= trial)
                begin
                    n_reg[k] <= n_in - trial;
                    r_reg[k] <= (r_in >> 1) + BIT;
                end
                else
                begin
                    n_reg[k] <= n_in;
                    r_reg[k] <= r_in >> 1;
                end
                sside_reg[k] <= s_in;
            end
        end
    end

    // Restoring division, one quotient bit per stage, three lanes
    for (genvar j = 0; j < DN; j++)
    begin : g_div
        localparam int K = DN - 1 - j;
        logic [2:0][61:0]    rem_in;
        logic [2:0][30:0]    q_in;
        logic [31:0]         len_in;
        lav_pkg::norm_side_t s_in;
        logic [62:0]         dsr;

        if (j == 0)
        begin : g_first
            assign len_in = r_reg[SN-1][31:0];
            assign s_in   = sside_reg[SN-1];
            assign q_in   = '0;
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = (62'(s_in.mag[i]) << FB) + 62'(len_in >> 1);
            end
        end
        else
        begin : g_next
            assign len_in = len_reg[j-1];
            assign s_in   = dside_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign rem_in = rem_reg[j-1];
        end

        assign dsr = 63'(len_in) << K;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ({1'b0, rem_in[i]} >= dsr)
                    begin
                        rem_reg[j][i] <= rem_in[i] - dsr[61:0];
                        q_reg[j][i]   <= q_in[i] | (31'd1 << K);
                    end
                    else
                    begin
                        rem_reg[j][i] <= rem_in[i];
                        q_reg[j][i]   <= q_in[i];
                    end
                end
                len_reg[j]   <= len_in;
                dside_reg[j] <= s_in;
            end
        end
    end

    // Apply sign; a zero vector stays zero
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dside_reg[DN-1].zero)
                begin
                    u_reg[i] <= '0;
                end
                else if (dside_reg[DN-1].neg[i])
                begin
                    u_reg[i] <= 32'd0 - {1'b0, q_reg[DN-1][i]};
                end
                else
                begin
                    u_reg[i] <= {1'b0, q_reg[DN-1][i]};
                end
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign u         = u_reg;

endmodule

// File: rtl/core/lav_cross.sv
// Two-stage cross product: products, then differences.
module lav_cross #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ce,
    input  logic                    in_valid,
    input  logic [2:0][AW-1:0]      a,
    input  logic [2:0][BW-1:0]      b,
    output logic                    out_valid,
    output logic [2:0][AW+BW-1:0]   r
);

    localparam int RW = AW + BW;

    logic [1:0]          vld_reg;
    logic [5:0][RW-1:0]  prod_reg;
    logic [2:0][RW-1:0]  r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            prod_reg[0] <= RW'($signed(a[1])) * RW'($signed(b[2]));
            prod_reg[1] <= RW'($signed(a[2])) * RW'($signed(b[1]));
            prod_reg[2] <= RW'($signed(a[2])) * RW'($signed(b[0]));
            prod_reg[3] <= RW'($signed(a[0])) * RW'($signed(b[2]));
            prod_reg[4] <= RW'($signed(a[0])) * RW'($signed(b[1]));
            prod_reg[5] <= RW'($signed(a[1])) * RW'($signed(b[0]));
            r_reg[0]    <= prod_reg[0] - prod_reg[1];
            r_reg[1]    <= prod_reg[2] - prod_reg[3];
            r_reg[2]    <= prod_reg[4] - prod_reg[5];
        end
    end

    assign out_valid = vld_reg[1];
    assign r         = r_reg;

endmodule

// File: rtl/core/lav_shift.sv
// Output stage: view translation per axis, rounded and saturated, axes held alongside.
module lav_shift (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [2:0][31:0]    right,
    input  logic [2:0][31:0]    upward,
    input  logic [2:0][31:0]    back,
    input  logic [2:0][31:0]    eye,
    output logic                out_valid,
    output logic [11:0][31:0]   res
);

    localparam int LAT = lav_pkg::SHIFT_LAT;

    logic [LAT-1:0]               vld_reg;
    logic [2:0][2:0][63:0]        prod_reg;
    logic [2:0][65:0]             t_reg;
    logic [8:0][31:0]             ax1_reg, ax2_reg;
    logic [11:0][31:0]            res_reg;
    logic [2:0][2:0][31:0]        axes;

    assign axes[0] = right;
    assign axes[1] = upward;
    assign axes[2] = back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [35:0] q;
        if (ce)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[a][i] <= 64'($signed(axes[a][i])) * 64'($signed(eye[i]));
                end
                // Negate the dot product and add half an output unit
                t_reg[a] <= 66'(1 << 29) - (66'($signed(prod_reg[a][0]))
                          + 66'($signed(prod_reg[a][1])) + 66'($signed(prod_reg[a][2])));
                q = 36'($signed(t_reg[a]) >>> lav_pkg::FRAC_BITS);
                if (q > 36'sh07FFFFFFF)
                begin
                    res_reg[9+a] <= 32'h7FFFFFFF;
                end
                else if (q < -36'sh080000000)
                begin
                    res_reg[9+a] <= 32'h80000000;
                end
                else
                begin
                    res_reg[9+a] <= q[31:0];
                end
            end
            ax1_reg <= {back, upward, right};
            ax2_reg <= ax1_reg;
            res_reg[8:0] <= ax2_reg;
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign res       = res_reg;

endmodule

// File: rtl/core/look_at_view_matrix.sv
// Top level of the look-at view matrix pipeline.
//
// Usage: one input transfer on the s_axis channel carries eye, target and up
// (signed Q15.16); one output transfer on the m_axis channel returns the
// right, upward and back axes (signed Q1.30) and the view translation
// (Q15.16, saturated). Every input transfer yields exactly one output.
//
// Data passes from input transfer to output valid as follows: the input
// register loads on the transfer edge, then three normalisers of 70 stages
// (32 square-root digit stages and 31 division bit stages each), two
// cross-product units of 2 stages and a 3-stage translation unit.
// Throughput: one item per cycle while the output is not stalled.
//
// Stall: the whole pipeline advances under one enable, held low while the
// output register holds a result the receiver has not taken; s_axis_tready
// follows that enable, so nothing is dropped or repeated.
// Reset: clears every valid bit; no result is pending afterwards.
module look_at_view_matrix (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // right_x/y/z, upward_x/y/z, back_x/y/z, shift_x/y/z
    output logic [383:0] m_axis_tdata
);

    localparam int N = lav_pkg::NORM_LAT;
    localparam int C = lav_pkg::CROSS_LAT;

    logic ce;

    logic              in_vld_reg;
    logic [2:0][32:0]  diff_reg;
    logic [2:0][31:0]  eye_reg, up_reg;

    logic              back_vld, rraw_vld, right_vld, uraw_vld, upw_vld, out_vld;
    logic [2:0][31:0]  back, right, upw, up_d, eye_d, back_d1, back_d2, right_d;
    logic [2:0][63:0]  rraw, uraw;
    logic [11:0][31:0] res;

    // Advance everything whenever the output slot is free or being taken
    assign ce            = !out_vld || m_axis_tready;
    assign s_axis_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    // Register the inputs and form eye minus target at full width
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i]  <= s_axis_tdata[32*i +: 32];
                up_reg[i]   <= s_axis_tdata[32*(6+i) +: 32];
                diff_reg[i] <= {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]}
                             - {s_axis_tdata[32*(3+i)+31], s_axis_tdata[32*(3+i) +: 32]};
            end
        end
    end

    lav_norm #(.W(33)) u_norm_back (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .in_valid(in_vld_reg), .v(diff_reg),
        .out_valid(back_vld), .u(back)
    );

    lav_delay #(.W(96), .DEPTH(N)) u_dly_up (
        .clk(clk), .ce(ce), .din(up_reg), .dout(up_d)
    );

    lav_delay #(.W(96), .DEPTH(3 * N + 2 * C)) u_dly_eye (
        .clk(clk), .ce(ce), .din(eye_reg), .dout(eye_d)
    );

    // Right axis: up cross back
    lav_cross #(.AW(32), .BW(32)) u_cross_right (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .in_valid(back_vld), .a(up_d), .b(back),
        .out_valid(rraw_vld), .r(rraw)
    );

    lav_norm #(.W(64)) u_norm_right (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .in_valid(rraw_vld), .v(rraw),
        .out_valid(right_vld), .u(right)
    );

    lav_delay #(.W(96), .DEPTH(N + C)) u_dly_back1 (
        .clk(clk), .ce(ce), .din(back), .dout(back_d1)
    );

    // Upward axis: back cross right
    lav_cross #(.AW(32), .BW(32)) u_cross_up (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .in_valid(right_vld), .a(back_d1), .b(right),
        .out_valid(uraw_vld), .r(uraw)
    );

    lav_norm #(.W(64)) u_norm_up (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .in_valid(uraw_vld), .v(uraw),
        .out_valid(upw_vld), .u(upw)
    );

    lav_delay #(.W(96), .DEPTH(N + C)) u_dly_back2 (
        .clk(clk), .ce(ce), .din(back_d1), .dout(back_d2)
    );

    lav_delay #(.W(96), .DEPTH(N + C)) u_dly_right (
        .clk(clk), .ce(ce), .din(right), .dout(right_d)
    );

    // Translation and output register
    lav_shift u_shift (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .in_valid(upw_vld),
        .right(right_d), .upward(upw), .back(back_d2), .eye(eye_d),
        .out_valid(out_vld), .res(res)
    );

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = res;

endmodule

// File: tb/sv/look_at_view_matrix_tb.sv
// Self-checking testbench for the look-at view matrix pipeline.
module look_at_view_matrix_tb;

    localparam int LATENCY    = 218;
    localparam int N_RANDOM   = 1330;
    localparam int IDLE_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    logic [287:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // right_x/y/z, upward_x/y/z, back_x/y/z, shift_x/y/z
    logic [383:0] m_axis_tdata;

    logic [287:0] pending_views[$];
    logic [383:0] expected_frames[$];
    int           errors;
    int           idle_cycles;
    int           send_gap;
    int           take_gap;

    look_at_view_matrix dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = n;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Scale so the largest magnitude sits in [2^30, 2^31), then divide by length
    function automatic void unit_vector(input longint v[3], output longint u[3]);
        longint unsigned a[3];
        longint unsigned peak;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        int msb;
        peak = 0;
        sum  = 0;
        msb  = -1;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = abs64(v[i]);
            if (a[i] > peak)
                peak = a[i];
        end
        if (peak == 0)
        begin
            u = '{0, 0, 0};
            return;
        end
        while (msb < 63 && (peak >> (msb + 1)) != 0)
            msb++;
        for (int i = 0; i < 3; i++)
        begin
            if (msb > 30)
                a[i] = a[i] >> (msb - 30);
            else if (msb < 30)
                a[i] = a[i] << (30 - msb);
            sum += a[i] * a[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((a[i] << 30) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Minus axis dot eye, rounded half up from Q16.46 to Q15.16, saturated
    function automatic logic [31:0] view_shift(longint axis[3], longint eye[3]);
        longint t;
        longint q;
        t = -(axis[0] * eye[0] + axis[1] * eye[1] + axis[2] * eye[2]) + (64'sd1 <<< 29);
        q = t >>> 30;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic logic [383:0] predict_view(logic [287:0] view);
        longint eye[3], up[3], diff[3], back[3], rraw[3], right[3], uraw[3], upw[3];
        logic [383:0] r;
        for (int i = 0; i < 3; i++)
        begin
            eye[i]  = longint'($signed(view[32*i +: 32]));
            diff[i] = eye[i] - longint'($signed(view[32*(3+i) +: 32]));
            up[i]   = longint'($signed(view[32*(6+i) +: 32]));
        end
        unit_vector(diff, back);
        cross3(up, back, rraw);
        unit_vector(rraw, right);
        cross3(back, right, uraw);
        unit_vector(uraw, upw);
        for (int i = 0; i < 3; i++)
        begin
            r[32*i +: 32]     = right[i][31:0];
            r[32*(3+i) +: 32] = upw[i][31:0];
            r[32*(6+i) +: 32] = back[i][31:0];
        end
        r[32*9 +: 32]  = view_shift(right, eye);
        r[32*10 +: 32] = view_shift(upw, eye);
        r[32*11 +: 32] = view_shift(back, eye);
        return r;
    endfunction

    function automatic logic [287:0] make_view(logic [31:0] e[3], logic [31:0] t[3],
                                               logic [31:0] u[3]);
        logic [287:0] v;
        for (int i = 0; i < 3; i++)
        begin
            v[32*i +: 32]     = e[i];
            v[32*(3+i) +: 32] = t[i];
            v[32*(6+i) +: 32] = u[i];
        end
        return v;
    endfunction

    // Random coordinate: full range, small values, or an extreme
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2:    return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] e[3], t[3], u[3];
        logic [31:0] corner[4];
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000};
        // Eye equals target: everything zero
        e = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000};
        pending_views.push_back(make_view(e, e, '{32'h0, 32'h0001_0000, 32'h0}));
        // Up parallel to back, and zero up
        t = '{32'h0001_0000, 32'h0002_0000, 32'h0};
        pending_views.push_back(make_view(e, t, '{32'h0, 32'h0, 32'h0005_0000}));
        pending_views.push_back(make_view(e, t, '{32'h0, 32'h0, 32'h0}));
        // Plain camera on the z axis
        pending_views.push_back(make_view('{32'h0, 32'h0, 32'h000A_0000}, '{32'h0, 32'h0, 32'h0},
                                          '{32'h0, 32'h0001_0000, 32'h0}));
        // Extreme corners, driving the shift into saturation
        for (int k = 0; k < 4; k++)
        begin
            e = '{corner[k], corner[(k+1)%4], corner[(k+2)%4]};
            t = '{corner[(k+3)%4], corner[(k+2)%4], corner[(k+1)%4]};
            u = '{corner[(k+1)%4], corner[k], corner[(k+3)%4]};
            pending_views.push_back(make_view(e, t, u));
            pending_views.push_back(make_view('{3{corner[k]}}, '{3{corner[(k+1)%4]}},
                                              '{3{corner[(k+2)%4]}}));
        end
        pending_views.push_back({288{1'b1}});
        pending_views.push_back({9{32'h8000_0000}});
        for (int n = 0; n < N_RANDOM; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e[i] = rand_coord();
                t[i] = $urandom_range(0, 9) == 0 ? e[i] : rand_coord();
                u[i] = rand_coord();
            end
            if ($urandom_range(0, 19) == 0)
                u = '{e[0] - t[0], e[1] - t[1], e[2] - t[2]};
            pending_views.push_back(make_view(e, t, u));
        end
    end

    // Driver: present the oldest pending view, hold it until transferred
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_frames.push_back(predict_view(s_axis_tdata));
                void'(pending_views.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the current transfer
            end
            else if (send_gap > 0 || pending_views.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_views[0];
                send_gap      <= ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
            end
        end
    end

    // Monitor: check each output transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            take_gap      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output %h", $time, m_axis_tdata);
                end
                else
                begin
                    for (int f = 0; f < 12; f++)
                        if (m_axis_tdata[32*f +: 32] !== expected_frames[0][32*f +: 32])
                        begin
                            errors++;
                            $display("%0t: field %0d expected %h actual %h", $time, f,
                                     expected_frames[0][32*f +: 32], m_axis_tdata[32*f +: 32]);
                        end
                    void'(expected_frames.pop_front());
                end
            end
            if (take_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                take_gap      <= take_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                take_gap      <= $urandom_range(0, 2) == 0 ? pick_gap() : 0;
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side, stop with an error at the limit
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[look_at_view_matrix] ERROR");
            $finish;
        end
    end

    initial
    begin
        errors        = 0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wait (pending_views.size() == 0 && !s_axis_tvalid);
        wait (expected_frames.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0 && expected_frames.size() == 0)
            $display("[look_at_view_matrix] OK");
        else
            $display("[look_at_view_matrix] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lav_pkg.sv
rtl/core/lav_delay.sv
rtl/core/lav_norm.sv
rtl/core/lav_cross.sv
rtl/core/lav_shift.sv
rtl/core/look_at_view_matrix.sv
tb/sv/look_at_view_matrix_tb.sv
